/* hw/rtl/tofm_pkg.sv */
`timescale 1ns / 1ps
package tofm_pkg;

	localparam int COORD_BITS = 20;
	localparam int DW = COORD_BITS + 1;
	localparam int NORM_BITS = 24;
	localparam int SH_W = $clog2(NORM_BITS);
	localparam int ROOT_W = 25;
	localparam int SQ_W = 66;
	localparam int DIV_W = 64;
	localparam int Q_W = 32;
	localparam int PA_W = Q_W + NORM_BITS;
	localparam int LRAD_W = 2 * DW + 2;
	localparam int NRAD_W = 2 * NORM_BITS + 2;
	localparam int GEO_STEPS = 25;
	localparam int DEN_STEPS = 25;
	localparam int PM_STEPS = 32;
	localparam int EN_STEPS = 33;
	localparam int BETA_BITS = 16;
	localparam int BN_W = 53;
	localparam int TIME_W = 24;
	localparam int MASS_W = 24;
	localparam int PATH_W = 21;
	localparam int CFG_IDX_W = 8;

	localparam logic [26:0] BETA_NUM = 27'd78125000;
	localparam logic [27:0] BETA_DEN = 28'd149896229;
	localparam logic [PATH_W-1:0] PATH_MAX = 21'h1FFFFF;
	localparam logic [Q_W-1:0] MOM_POS_MAX = 32'h7FFF_FFFF;
	localparam logic [Q_W-1:0] MOM_NEG_MAX = 32'h8000_0000;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ORIGIN = 2'd1;
	localparam logic [1:0] ST_BETA = 2'd2;
	localparam logic [1:0] ST_SAT = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_X = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_Y = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_Z = 8'd2;

	typedef struct packed {
		logic [SQ_W-1:0] op;
		logic [SQ_W-1:0] res;
	} sq_t;

	typedef struct packed {
		logic [DIV_W-1:0] rem;
		logic [Q_W-1:0] q;
	} dv_t;

	typedef struct packed {
		logic [2:0][COORD_BITS-1:0] start;
		logic [2:0][COORD_BITS-1:0] hit;
		logic [2:0][COORD_BITS-1:0] dir;
		logic [TIME_W-1:0] t;
		logic [MASS_W-1:0] m;
	} trk_t;

	typedef struct packed {
		logic ho;
		logic dz;
		logic [2:0] neg;
		logic [2:0][NORM_BITS-1:0] an;
		logic [MASS_W-1:0] m;
		logic [TIME_W-1:0] t;
		logic [ROOT_W-1:0] path;
		logic [ROOT_W-1:0] n;
	} ctx_t;

	typedef struct packed {
		ctx_t ctx;
		logic ge;
		logic [BETA_BITS-1:0] b;
		logic [Q_W-1:0] pmag;
	} kin_t;

	typedef struct packed {
		logic [2:0][Q_W-1:0] mom;
		logic [Q_W-1:0] energy;
		logic [BETA_BITS-1:0] beta;
		logic [PATH_W-1:0] path;
		logic [1:0] status;
	} res_t;

	// one digit of a restoring square root
	function automatic sq_t sq_step(input sq_t s, input int unsigned k);
		logic [SQ_W-1:0] one;
		logic [SQ_W-1:0] trial;
		sq_t r;
		one = SQ_W'(1) << (2 * k);
		trial = s.res + one;
		if (s.op >= trial) begin
			r.op = s.op - trial;
			r.res = (s.res >> 1) + one;
		end else begin
			r.op = s.op;
			r.res = s.res >> 1;
		end
		return r;
	endfunction

	// one quotient bit of a restoring division
	function automatic dv_t dv_step(input dv_t s, input logic [Q_W-1:0] d, input int unsigned k);
		logic [DIV_W-1:0] sd;
		dv_t r;
		sd = DIV_W'(d) << k;
		r = s;
		if (s.rem >= sd) begin
			r.rem = s.rem - sd;
			r.q = s.q | (Q_W'(1) << k);
		end
		return r;
	endfunction

endpackage

/* hw/rtl/tofm_geom.sv */
`timescale 1ns / 1ps
module tofm_geom
	import tofm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_v,
	input trk_t in_trk,
	input logic [2:0][COORD_BITS-1:0] vtx,
	output logic out_v,
	output ctx_t out_ctx
);

	logic derive_c;
	logic [2:0][DW-1:0] pd_c, dd_c, pm_c, am_c;
	logic [2:0] neg_c;
	ctx_t ctx_c;

	always_comb begin
		derive_c = (in_trk.dir == '0);
		for (int i = 0; i < 3; i++) begin
			pd_c[i] = {in_trk.hit[i][COORD_BITS-1], in_trk.hit[i]}
				- {vtx[i][COORD_BITS-1], vtx[i]};
			dd_c[i] = derive_c
				? ({in_trk.hit[i][COORD_BITS-1], in_trk.hit[i]}
					- {in_trk.start[i][COORD_BITS-1], in_trk.start[i]})
				: {in_trk.dir[i][COORD_BITS-1], in_trk.dir[i]};
			pm_c[i] = pd_c[i][DW-1] ? (~pd_c[i] + 1'b1) : pd_c[i];
			am_c[i] = dd_c[i][DW-1] ? (~dd_c[i] + 1'b1) : dd_c[i];
			neg_c[i] = dd_c[i][DW-1];
		end
		ctx_c = '0;
		ctx_c.ho = (in_trk.hit == '0);
		ctx_c.dz = (am_c == '0);
		ctx_c.neg = neg_c;
		ctx_c.m = in_trk.m;
		ctx_c.t = in_trk.t;
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [2:0][DW-1:0] pm_s1, am_s1, am_s2;
	logic [2:0][2*DW-1:0] sq_s2;
	logic [SH_W-1:0] sh_s2;
	logic [LRAD_W-1:0] lrad_s3, lrad_s4, lrad_s5;
	logic [2:0][2*NORM_BITS-1:0] nsq_s4;
	logic [NRAD_W-1:0] nrad_s5;
	ctx_t ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5;

	logic [DW-1:0] mx_c;
	logic [SH_W-1:0] msb_c;
	logic [2:0][2*DW-1:0] sq_c;
	logic [LRAD_W-1:0] lrad_c;
	logic [2:0][NORM_BITS-1:0] an_c;
	logic [2:0][2*NORM_BITS-1:0] nsq_c;
	logic [NRAD_W-1:0] nrad_c;
	ctx_t ctx3_c;

	always_comb begin
		mx_c = am_s1[0];
		if (am_s1[1] > mx_c) begin
			mx_c = am_s1[1];
		end
		if (am_s1[2] > mx_c) begin
			mx_c = am_s1[2];
		end
		msb_c = '0;
		for (int i = 0; i < DW; i++) begin
			if (mx_c[i]) begin
				msb_c = SH_W'(i);
			end
		end
		for (int i = 0; i < 3; i++) begin
			sq_c[i] = (2*DW)'(pm_s1[i]) * (2*DW)'(pm_s1[i]);
			an_c[i] = NORM_BITS'(am_s2[i]) << sh_s2;
			nsq_c[i] = (2*NORM_BITS)'(ctx_s3.an[i]) * (2*NORM_BITS)'(ctx_s3.an[i]);
		end
		lrad_c = LRAD_W'(sq_s2[0]) + LRAD_W'(sq_s2[1]) + LRAD_W'(sq_s2[2]);
		nrad_c = NRAD_W'(nsq_s4[0]) + NRAD_W'(nsq_s4[1]) + NRAD_W'(nsq_s4[2]);
		ctx3_c = ctx_s2;
		ctx3_c.an = an_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pm_s1 <= pm_c;
			am_s1 <= am_c;
			ctx_s1 <= ctx_c;
			sq_s2 <= sq_c;
			am_s2 <= am_s1;
			sh_s2 <= SH_W'(NORM_BITS - 1) - msb_c;
			ctx_s2 <= ctx_s1;
			lrad_s3 <= lrad_c;
			ctx_s3 <= ctx3_c;
			lrad_s4 <= lrad_s3;
			nsq_s4 <= nsq_c;
			ctx_s4 <= ctx_s3;
			lrad_s5 <= lrad_s4;
			nrad_s5 <= nrad_c;
			ctx_s5 <= ctx_s4;
		end
	end

	// path length and direction norm roots side by side
	sq_t lsq_s [GEO_STEPS];
	sq_t nsq_s [GEO_STEPS];
	ctx_t cq_s [GEO_STEPS];
	logic [GEO_STEPS-1:0] sv_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_s <= '0;
		end else if (en) begin
			sv_s <= {sv_s[GEO_STEPS-2:0], v_s5};
		end
	end

	for (genvar j = 0; j < GEO_STEPS; j++) begin : g_root
		sq_t l_prev, n_prev;
		ctx_t c_prev;
		if (j == 0) begin : g_first
			assign l_prev = '{op: SQ_W'(lrad_s5), res: '0};
			assign n_prev = '{op: SQ_W'(nrad_s5), res: '0};
			assign c_prev = ctx_s5;
		end else begin : g_next
			assign l_prev = lsq_s[j-1];
			assign n_prev = nsq_s[j-1];
			assign c_prev = cq_s[j-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				lsq_s[j] <= sq_step(l_prev, GEO_STEPS - 1 - j);
				nsq_s[j] <= sq_step(n_prev, GEO_STEPS - 1 - j);
				cq_s[j] <= c_prev;
			end
		end
	end

	always_comb begin
		out_ctx = cq_s[GEO_STEPS-1];
		out_ctx.path = lsq_s[GEO_STEPS-1].res[ROOT_W-1:0];
		out_ctx.n = nsq_s[GEO_STEPS-1].res[ROOT_W-1:0];
	end
	assign out_v = sv_s[GEO_STEPS-1];

endmodule

/* hw/rtl/tofm_kin.sv */
`timescale 1ns / 1ps
module tofm_kin
	import tofm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_v,
	input ctx_t in_ctx,
	output logic out_v,
	output kin_t out_k
);

	typedef struct packed {
		logic [BN_W-1:0] n;
		logic [BETA_BITS-1:0] b;
		logic ge;
	} bd_t;

	typedef struct packed {
		ctx_t ctx;
		logic ge;
		logic [BETA_BITS-1:0] b;
	} kc_t;

	logic v_s1, v_s18, v_s19;
	logic [BN_W-1:0] n_s1, d_s1;
	ctx_t ctx_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1 <= BN_W'(in_ctx.path) * BN_W'(BETA_NUM);
			d_s1 <= BN_W'(BETA_DEN) * BN_W'(in_ctx.t);
			ctx_s1 <= in_ctx;
		end
	end

	// beta, one quotient bit per stage
	bd_t bd_s [BETA_BITS];
	logic [BN_W-1:0] bdd_s [BETA_BITS];
	ctx_t bc_s [BETA_BITS];
	logic [BETA_BITS-1:0] bv_s;

	for (genvar j = 0; j < BETA_BITS; j++) begin : g_beta
		bd_t p, nx;
		logic [BN_W-1:0] d_prev;
		ctx_t c_prev;
		logic [BN_W-1:0] nn;
		if (j == 0) begin : g_first
			assign p = '{n: n_s1, b: '0, ge: 1'b0};
			assign d_prev = d_s1;
			assign c_prev = ctx_s1;
		end else begin : g_next
			assign p = bd_s[j-1];
			assign d_prev = bdd_s[j-1];
			assign c_prev = bc_s[j-1];
		end
		always_comb begin
			nx = p;
			if (j == 0) begin
				nx.ge = (p.n >= d_prev);
			end
			nn = {p.n[BN_W-2:0], 1'b0};
			nx.b = {p.b[BETA_BITS-2:0], 1'b0};
			if (nn >= d_prev) begin
				nn = nn - d_prev;
				nx.b[0] = 1'b1;
			end
			nx.n = nn;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				bd_s[j] <= nx;
				bdd_s[j] <= d_prev;
				bc_s[j] <= c_prev;
			end
		end
	end

	logic [2*BETA_BITS-1:0] bb_s18;
	logic [MASS_W+BETA_BITS-1:0] mb_s18;
	kc_t kc_s18, kc_s19;
	logic [SQ_W-1:0] rad_s19;
	logic [MASS_W+BETA_BITS+7:0] dvd_s19;
	logic [2*BETA_BITS:0] onem_c;

	assign onem_c = {1'b1, {(2*BETA_BITS){1'b0}}} - {1'b0, bb_s18};

	always_ff @(posedge clk) begin
		if (en) begin
			bb_s18 <= (2*BETA_BITS)'(bd_s[BETA_BITS-1].b) * (2*BETA_BITS)'(bd_s[BETA_BITS-1].b);
			mb_s18 <= (MASS_W+BETA_BITS)'(bc_s[BETA_BITS-1].m)
				* (MASS_W+BETA_BITS)'(bd_s[BETA_BITS-1].b);
			kc_s18 <= '{ctx: bc_s[BETA_BITS-1], ge: bd_s[BETA_BITS-1].ge,
				b: bd_s[BETA_BITS-1].b};
			rad_s19 <= SQ_W'(onem_c) << 16;
			dvd_s19 <= {mb_s18, 8'd0};
			kc_s19 <= kc_s18;
		end
	end

	// sqrt(1 - beta^2) in Q0.24
	sq_t ds_s [DEN_STEPS];
	kc_t dk_s [DEN_STEPS];
	logic [MASS_W+BETA_BITS+7:0] ddv_s [DEN_STEPS];
	logic [DEN_STEPS-1:0] dv_s;

	for (genvar j = 0; j < DEN_STEPS; j++) begin : g_den
		sq_t p;
		kc_t k_prev;
		logic [MASS_W+BETA_BITS+7:0] x_prev;
		if (j == 0) begin : g_first
			assign p = '{op: rad_s19, res: '0};
			assign k_prev = kc_s19;
			assign x_prev = dvd_s19;
		end else begin : g_next
			assign p = ds_s[j-1];
			assign k_prev = dk_s[j-1];
			assign x_prev = ddv_s[j-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				ds_s[j] <= sq_step(p, DEN_STEPS - 1 - j);
				dk_s[j] <= k_prev;
				ddv_s[j] <= x_prev;
			end
		end
	end

	// momentum magnitude
	dv_t qs_s [PM_STEPS];
	kc_t qk_s [PM_STEPS];
	logic [ROOT_W-1:0] qd_s [PM_STEPS];
	logic [PM_STEPS-1:0] qv_s;

	for (genvar j = 0; j < PM_STEPS; j++) begin : g_pm
		dv_t p;
		kc_t k_prev;
		logic [ROOT_W-1:0] d_prev;
		if (j == 0) begin : g_first
			assign p = '{rem: DIV_W'(ddv_s[DEN_STEPS-1]), q: '0};
			assign k_prev = dk_s[DEN_STEPS-1];
			assign d_prev = ds_s[DEN_STEPS-1].res[ROOT_W-1:0];
		end else begin : g_next
			assign p = qs_s[j-1];
			assign k_prev = qk_s[j-1];
			assign d_prev = qd_s[j-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				qs_s[j] <= dv_step(p, Q_W'(d_prev), PM_STEPS - 1 - j);
				qk_s[j] <= k_prev;
				qd_s[j] <= d_prev;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			bv_s <= '0;
			v_s18 <= 1'b0;
			v_s19 <= 1'b0;
			dv_s <= '0;
			qv_s <= '0;
		end else if (en) begin
			v_s1 <= in_v;
			bv_s <= {bv_s[BETA_BITS-2:0], v_s1};
			v_s18 <= bv_s[BETA_BITS-1];
			v_s19 <= v_s18;
			dv_s <= {dv_s[DEN_STEPS-2:0], v_s19};
			qv_s <= {qv_s[PM_STEPS-2:0], dv_s[DEN_STEPS-1]};
		end
	end

	assign out_v = qv_s[PM_STEPS-1];
	assign out_k = '{ctx: qk_s[PM_STEPS-1].ctx, ge: qk_s[PM_STEPS-1].ge,
		b: qk_s[PM_STEPS-1].b, pmag: qs_s[PM_STEPS-1].q};

endmodule

/* hw/rtl/tofm_out.sv */
`timescale 1ns / 1ps
module tofm_out
	import tofm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_v,
	input kin_t in_k,
	output logic out_v,
	output res_t out_res
);

	logic v_s1, v_s2;
	logic [2*Q_W-1:0] pe_s1;
	logic [2*MASS_W-1:0] mm_s1;
	logic [2:0][PA_W-1:0] pa_s1, pa_s2;
	logic [SQ_W-1:0] erad_s2;
	kin_t k_s1, k_s2;
	logic [2:0][PA_W-1:0] pa_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pa_c[i] = PA_W'(in_k.pmag) * PA_W'(in_k.ctx.an[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pe_s1 <= (2*Q_W)'(in_k.pmag) * (2*Q_W)'(in_k.pmag);
			mm_s1 <= (2*MASS_W)'(in_k.ctx.m) * (2*MASS_W)'(in_k.ctx.m);
			pa_s1 <= pa_c;
			k_s1 <= in_k;
			erad_s2 <= SQ_W'(pe_s1) + SQ_W'(mm_s1);
			pa_s2 <= pa_s1;
			k_s2 <= k_s1;
		end
	end

	// energy root and the three component divisions in step
	sq_t es_s [EN_STEPS];
	dv_t md_s [EN_STEPS][3];
	kin_t ek_s [EN_STEPS];
	logic [EN_STEPS-1:0] ev_s;

	for (genvar j = 0; j < EN_STEPS; j++) begin : g_en
		sq_t e_prev;
		dv_t m_prev [3];
		kin_t k_prev;
		if (j == 0) begin : g_first
			assign e_prev = '{op: erad_s2, res: '0};
			assign k_prev = k_s2;
			for (genvar i = 0; i < 3; i++) begin : g_seed
				assign m_prev[i] = '{rem: DIV_W'(pa_s2[i]), q: '0};
			end
		end else begin : g_next
			assign e_prev = es_s[j-1];
			assign k_prev = ek_s[j-1];
			for (genvar i = 0; i < 3; i++) begin : g_link
				assign m_prev[i] = md_s[j-1][i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				es_s[j] <= sq_step(e_prev, EN_STEPS - 1 - j);
				ek_s[j] <= k_prev;
				for (int i = 0; i < 3; i++) begin
					if (j == 0) begin
						md_s[j][i] <= m_prev[i];
					end else begin
						md_s[j][i] <= dv_step(m_prev[i], Q_W'(k_prev.ctx.n), EN_STEPS - 1 - j);
					end
				end
			end
		end
	end

	kin_t kf_c;
	res_t res_c;
	logic path_sat_c, mom_sat_c;
	logic [Q_W-1:0] q_c;

	always_comb begin
		kf_c = ek_s[EN_STEPS-1];
		path_sat_c = (kf_c.ctx.path > ROOT_W'(PATH_MAX));
		mom_sat_c = 1'b0;
		res_c = '0;
		res_c.path = path_sat_c ? PATH_MAX : kf_c.ctx.path[PATH_W-1:0];
		for (int i = 0; i < 3; i++) begin
			q_c = md_s[EN_STEPS-1][i].q;
			if (kf_c.ctx.neg[i]) begin
				if (q_c > MOM_NEG_MAX) begin
					res_c.mom[i] = MOM_NEG_MAX;
					mom_sat_c = mom_sat_c | ~kf_c.ctx.dz;
				end else begin
					res_c.mom[i] = ~q_c + 1'b1;
				end
			end else begin
				if (q_c > MOM_POS_MAX) begin
					res_c.mom[i] = MOM_POS_MAX;
					mom_sat_c = mom_sat_c | ~kf_c.ctx.dz;
				end else begin
					res_c.mom[i] = q_c;
				end
			end
		end
		if (kf_c.ctx.dz) begin
			res_c.mom = '0;
		end
		res_c.energy = es_s[EN_STEPS-1].res[Q_W-1:0];
		res_c.beta = kf_c.b;
		res_c.status = (path_sat_c || mom_sat_c) ? ST_SAT : ST_OK;
		if (kf_c.ctx.ho) begin
			res_c = '0;
			res_c.status = ST_ORIGIN;
		end else if (kf_c.ge) begin
			res_c.mom = '0;
			res_c.energy = Q_W'(kf_c.ctx.m);
			res_c.beta = '0;
			res_c.status = ST_BETA;
		end
	end

	logic v_sf;
	res_t res_sf;

	always_ff @(posedge clk) begin
		if (en) begin
			res_sf <= res_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			ev_s <= '0;
			v_sf <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			ev_s <= {ev_s[EN_STEPS-2:0], v_s2};
			v_sf <= ev_s[EN_STEPS-1];
		end
	end

	assign out_v = v_sf;
	assign out_res = res_sf;

endmodule

/* hw/rtl/tof_track_momentum_top.sv */
`timescale 1ns / 1ps
// time of flight momentum per track
// track channel: trk_valid / trk_stall with start, hit, direction, flight time
// and mass hypothesis; a beat is taken when trk_valid is high and trk_stall low
// result channel: res_valid / res_stall with momentum, energy, beta, path
// length and status
// vertex registers: cfg_valid / cfg_ready write port, index 0..2 for x, y, z;
// other indexes are ignored; write only while no track is in flight
// throughput: one track per cycle while trk_stall is low, no gaps between beats
// pipeline from track beat to result: 30 stages of path and
// direction roots, 76 of beta division, denominator root and magnitude
// division, 36 of energy root and component division, plus the output register
// when res_stall holds a result the next result parks in a skid register and
// trk_stall rises as the skid register fills, freezing the whole pipeline; nothing is lost
// reset clears all valid bits and the vertex to zero
module tof_track_momentum_top
	import tofm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic trk_valid,
	output logic trk_stall,
	input logic [COORD_BITS-1:0] start_x,
	input logic [COORD_BITS-1:0] start_y,
	input logic [COORD_BITS-1:0] start_z,
	input logic [COORD_BITS-1:0] hit_x,
	input logic [COORD_BITS-1:0] hit_y,
	input logic [COORD_BITS-1:0] hit_z,
	input logic [COORD_BITS-1:0] dir_x,
	input logic [COORD_BITS-1:0] dir_y,
	input logic [COORD_BITS-1:0] dir_z,
	input logic [TIME_W-1:0] flight_time,
	input logic [MASS_W-1:0] mass_hyp,
	output logic res_valid,
	input logic res_stall,
	output logic [Q_W-1:0] mom_x,
	output logic [Q_W-1:0] mom_y,
	output logic [Q_W-1:0] mom_z,
	output logic [Q_W-1:0] energy,
	output logic [BETA_BITS-1:0] beta,
	output logic [PATH_W-1:0] path_length,
	output logic [1:0] status,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [COORD_BITS-1:0] cfg_data
);

	logic [2:0][COORD_BITS-1:0] vtx_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtx_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_VERTEX_X: vtx_q[0] <= cfg_data;
				REG_VERTEX_Y: vtx_q[1] <= cfg_data;
				REG_VERTEX_Z: vtx_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic skid_v_q, res_v_q;
	res_t skid_q, res_q;
	trk_t trk;
	logic g_v, k_v, o_v;
	ctx_t g_ctx;
	kin_t k_k;
	res_t o_res;

	assign en = !skid_v_q;
	assign trk_stall = skid_v_q;

	assign trk.start = {start_z, start_y, start_x};
	assign trk.hit = {hit_z, hit_y, hit_x};
	assign trk.dir = {dir_z, dir_y, dir_x};
	assign trk.t = flight_time;
	assign trk.m = mass_hyp;

	tofm_geom u_geom (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_v(trk_valid),
		.in_trk(trk),
		.vtx(vtx_q),
		.out_v(g_v),
		.out_ctx(g_ctx)
	);

	tofm_kin u_kin (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_v(g_v),
		.in_ctx(g_ctx),
		.out_v(k_v),
		.out_k(k_k)
	);

	tofm_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_v(k_v),
		.in_k(k_k),
		.out_v(o_v),
		.out_res(o_res)
	);

	logic res_take;
	assign res_take = res_v_q && !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (res_take) begin
				skid_v_q <= 1'b0;
			end
		end else if (!res_v_q || res_take) begin
			res_v_q <= o_v;
		end else if (o_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (res_take) begin
				res_q <= skid_q;
			end
		end else if (!res_v_q || res_take) begin
			res_q <= o_res;
		end else if (o_v) begin
			skid_q <= o_res;
		end
	end

	assign res_valid = res_v_q;
	assign mom_x = res_q.mom[0];
	assign mom_y = res_q.mom[1];
	assign mom_z = res_q.mom[2];
	assign energy = res_q.energy;
	assign beta = res_q.beta;
	assign path_length = res_q.path;
	assign status = res_q.status;

`ifndef NO_ASSERTIONS
	a_skid_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> res_v_q)
		else $error("skid beat without output beat");

	a_skid_refill: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && res_take) |=> (res_valid && !skid_v_q))
		else $error("skid beat dropped");

	a_origin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && status == ST_ORIGIN) |-> (energy == '0 && path_length == '0
			&& beta == '0))
		else $error("origin hit with nonzero result");

	a_beta_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && status == ST_BETA) |-> (mom_x == '0 && mom_y == '0
			&& mom_z == '0 && beta == '0))
		else $error("superluminal track with momentum");
`endif

endmodule

/* tb/tb_tof_track_momentum_top.sv */
`timescale 1ns / 1ps
module tb_tof_track_momentum_top;
	import tofm_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd3;
	localparam int DRAIN_CYCLES = 160;
	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PHASES = 5;
	localparam int PHASE_ITEMS = 218;

	typedef struct {
		trk_t tr;
		bit typed;
		res_t want;
	} row_t;

	logic clk;
	logic arst_n;
	logic trk_valid;
	logic trk_stall;
	logic [COORD_BITS-1:0] start_x, start_y, start_z;
	logic [COORD_BITS-1:0] hit_x, hit_y, hit_z;
	logic [COORD_BITS-1:0] dir_x, dir_y, dir_z;
	logic [TIME_W-1:0] flight_time;
	logic [MASS_W-1:0] mass_hyp;
	logic res_valid;
	logic res_stall;
	logic [Q_W-1:0] mom_x, mom_y, mom_z, energy;
	logic [BETA_BITS-1:0] beta;
	logic [PATH_W-1:0] path_length;
	logic [1:0] status;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COORD_BITS-1:0] cfg_data;

	longint vtx[3];
	res_t pending_res[$];
	row_t rows[$];
	int errors;
	int idle_cycles;
	bit no_idle;
	bit long_hold;

	tof_track_momentum_top uut (
		.clk(clk), .arst_n(arst_n),
		.trk_valid(trk_valid), .trk_stall(trk_stall),
		.start_x(start_x), .start_y(start_y), .start_z(start_z),
		.hit_x(hit_x), .hit_y(hit_y), .hit_z(hit_z),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.flight_time(flight_time), .mass_hyp(mass_hyp),
		.res_valid(res_valid), .res_stall(res_stall),
		.mom_x(mom_x), .mom_y(mom_y), .mom_z(mom_z),
		.energy(energy), .beta(beta), .path_length(path_length), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [63:0] int_root(input logic [127:0] v);
		logic [127:0] c;
		logic [63:0] r;
		r = '0;
		for (int bit_i = 40; bit_i >= 0; bit_i--) begin
			c = 128'(r | (64'd1 << bit_i));
			if (c * c <= v)
				r = c[63:0];
		end
		return r;
	endfunction

	function automatic logic [63:0] path_of(input trk_t tr);
		longint d;
		longint acc;
		acc = 0;
		for (int i = 0; i < 3; i++) begin
			d = longint'(signed'(tr.hit[i])) - vtx[i];
			acc += d * d;
		end
		return int_root(128'(acc));
	endfunction

	function automatic res_t predict_track(input trk_t tr);
		longint hv[3], dd[3];
		logic [63:0] len, num, dnm, b, den, pmag, nrm, q, mx, mm, erg;
		logic [63:0] am[3];
		logic [127:0] acc;
		bit derive;
		res_t r;
		r = '0;
		for (int i = 0; i < 3; i++)
			hv[i] = longint'(signed'(tr.hit[i]));
		if (hv[0] == 0 && hv[1] == 0 && hv[2] == 0) begin
			r.status = ST_ORIGIN;
			return r;
		end
		len = path_of(tr);
		if (len > 64'(PATH_MAX)) begin
			r.path = PATH_MAX;
			r.status = ST_SAT;
		end else begin
			r.path = len[PATH_W-1:0];
		end
		mm = 64'(tr.m);
		num = len * 64'd78125000;
		dnm = 64'd149896229 * 64'(tr.t);
		if (num >= dnm) begin
			r.energy = 32'(tr.m);
			r.status = ST_BETA;
			return r;
		end
		b = '0;
		for (int i = 0; i < 16; i++) begin
			num = num << 1;
			b = b << 1;
			if (num >= dnm) begin
				num -= dnm;
				b |= 64'd1;
			end
		end
		den = int_root(128'(((64'd1 << 32) - b * b) << 16));
		pmag = (mm * b * 64'd256) / den;
		derive = (tr.dir[0] == '0 && tr.dir[1] == '0 && tr.dir[2] == '0);
		for (int i = 0; i < 3; i++) begin
			dd[i] = derive ? hv[i] - longint'(signed'(tr.start[i]))
				: longint'(signed'(tr.dir[i]));
			am[i] = dd[i] < 0 ? 64'(-dd[i]) : 64'(dd[i]);
		end
		if (am[0] != 0 || am[1] != 0 || am[2] != 0) begin
			mx = am[0];
			if (am[1] > mx) mx = am[1];
			if (am[2] > mx) mx = am[2];
			while (mx >= (64'd1 << 24)) begin
				mx = mx >> 1;
				for (int i = 0; i < 3; i++) am[i] = am[i] >> 1;
			end
			while (mx < (64'd1 << 23)) begin
				mx = mx << 1;
				for (int i = 0; i < 3; i++) am[i] = am[i] << 1;
			end
			nrm = int_root(128'(am[0] * am[0]) + 128'(am[1] * am[1]) + 128'(am[2] * am[2]));
			for (int i = 0; i < 3; i++) begin
				q = (pmag * am[i]) / nrm;
				if (dd[i] < 0) begin
					if (q > 64'h8000_0000) begin
						q = 64'h8000_0000;
						r.status = ST_SAT;
					end
					r.mom[i] = 32'(64'd0 - q);
				end else begin
					if (q > 64'h7FFF_FFFF) begin
						q = 64'h7FFF_FFFF;
						r.status = ST_SAT;
					end
					r.mom[i] = q[31:0];
				end
			end
		end
		acc = 128'(pmag) * 128'(pmag) + 128'(mm * mm);
		erg = int_root(acc);
		r.energy = erg[31:0];
		r.beta = b[15:0];
		return r;
	endfunction

	function automatic trk_t track_of(input int sx, sy, sz, hx, hy, hz, dx, dy, dz,
			input int unsigned t, input int unsigned m);
		trk_t tr;
		tr.start[0] = 20'(sx); tr.start[1] = 20'(sy); tr.start[2] = 20'(sz);
		tr.hit[0] = 20'(hx); tr.hit[1] = 20'(hy); tr.hit[2] = 20'(hz);
		tr.dir[0] = 20'(dx); tr.dir[1] = 20'(dy); tr.dir[2] = 20'(dz);
		tr.t = 24'(t);
		tr.m = 24'(m);
		return tr;
	endfunction

	function automatic trk_t random_track();
		trk_t tr;
		logic [63:0] len;
		int k;
		k = $urandom_range(0, 99);
		for (int i = 0; i < 3; i++) begin
			if (k < 40)
				tr.hit[i] = 20'($urandom);
			else
				tr.hit[i] = 20'(int'($urandom_range(0, 65535)) - 32768);
			if (k < 3)
				tr.hit[i] = '0;
			tr.start[i] = ($urandom_range(0, 3) == 0) ? 20'($urandom)
				: 20'(tr.hit[i] - 20'(int'($urandom_range(0, 8191)) - 4096));
			tr.dir[i] = ($urandom_range(0, 1) == 0) ? 20'($urandom)
				: 20'(int'($urandom_range(0, 2047)) - 1024);
		end
		if ($urandom_range(0, 4) == 0)
			tr.dir = '0;
		if ($urandom_range(0, 9) == 0)
			tr.start = tr.hit;
		tr.m = ($urandom_range(0, 1) == 0) ? 24'($urandom) : 24'($urandom_range(0, 1000000));
		len = path_of(tr);
		if ($urandom_range(0, 9) == 0)
			tr.t = 24'($urandom);
		else
			tr.t = 24'((len * 53) / 100 + 64'($urandom_range(0, 32'(len) + 1)));
		return tr;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic check_result();
		res_t want;
		if (pending_res.size() == 0) begin
			report_mismatch("unexpected beat", 64'(status), 64'd0);
			return;
		end
		want = pending_res.pop_front();
		if (mom_x !== want.mom[0])
			report_mismatch("mom_x", 64'(mom_x), 64'(want.mom[0]));
		if (mom_y !== want.mom[1])
			report_mismatch("mom_y", 64'(mom_y), 64'(want.mom[1]));
		if (mom_z !== want.mom[2])
			report_mismatch("mom_z", 64'(mom_z), 64'(want.mom[2]));
		if (energy !== want.energy)
			report_mismatch("energy", 64'(energy), 64'(want.energy));
		if (beta !== want.beta)
			report_mismatch("beta", 64'(beta), 64'(want.beta));
		if (path_length !== want.path)
			report_mismatch("path_length", 64'(path_length), 64'(want.path));
		if (status !== want.status)
			report_mismatch("status", 64'(status), 64'(want.status));
	endtask

	// entered and left at a falling edge
	task automatic send_track(input trk_t tr, input bit typed, input res_t want);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			trk_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start_x = tr.start[0]; start_y = tr.start[1]; start_z = tr.start[2];
		hit_x = tr.hit[0]; hit_y = tr.hit[1]; hit_z = tr.hit[2];
		dir_x = tr.dir[0]; dir_y = tr.dir[1]; dir_z = tr.dir[2];
		flight_time = tr.t;
		mass_hyp = tr.m;
		trk_valid = 1'b1;
		do @(posedge clk); while (trk_stall);
		pending_res.push_back(typed ? want : predict_track(tr));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		trk_valid = 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_vertex(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_index = idx;
		cfg_data = 20'(value);
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_VERTEX_X) vtx[0] = longint'(signed'(20'(value)));
		if (idx == REG_VERTEX_Y) vtx[1] = longint'(signed'(20'(value)));
		if (idx == REG_VERTEX_Z) vtx[2] = longint'(signed'(20'(value)));
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	always @(posedge clk) begin
		if ((trk_valid && !trk_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tof_track_momentum_top verification failed");
			$finish;
		end
	end

	// result side
	initial begin
		int n;
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				res_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				long_hold = 1'b0;
			end
			n = no_idle ? 0 : $urandom_range(0, 3);
			if (n > 0) begin
				res_stall = 1'b1;
				repeat (n) @(negedge clk);
			end
			res_stall = 1'b0;
			do @(posedge clk); while (!res_valid);
			check_result();
		end
	end

	initial begin
		res_t want;
		int vx, vy, vz;
		arst_n = 1'b0;
		trk_valid = 1'b0;
		{start_x, start_y, start_z, hit_x, hit_y, hit_z, dir_x, dir_y, dir_z} = '0;
		flight_time = '0;
		mass_hyp = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		idle_cycles = 0;
		no_idle = 1'b0;
		long_hold = 1'b0;
		vtx = '{0, 0, 0};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// hit at origin
		want = '0;
		want.status = ST_ORIGIN;
		rows.push_back('{track_of(5, 6, 7, 0, 0, 0, 1, 2, 3, 100, 1000), 1'b1, want});
		// zero flight time
		want = '0;
		want.energy = 32'd938272;
		want.path = 21'd64;
		want.status = ST_BETA;
		rows.push_back('{track_of(0, 0, 0, 64, 0, 0, 0, 0, 0, 0, 938272), 1'b1, want});
		want = '0;
		rows.push_back('{track_of(0, 0, 0, 64, 0, 0, 0, 0, 0, 1, 16777215), 1'b1, want});
		rows[2].want.energy = 32'd16777215;
		rows[2].want.path = 21'd64;
		rows[2].want.status = ST_BETA;
		rows.push_back('{track_of(0, 0, 0, 6400, 0, 0, 1, 0, 0, 5000, 938272), 1'b0, want});
		rows.push_back('{track_of(100, 200, 300, 6400, 3200, -1600, 0, 0, 0, 5000, 139570),
			1'b0, want});
		rows.push_back('{track_of(6400, 0, 0, 6400, 0, 0, 0, 0, 0, 5000, 105658), 1'b0, want});
		rows.push_back('{track_of(0, 0, 0, 524287, 524287, 524287, 524287, -524288, 524287,
			473500, 16777215), 1'b0, want});
		rows.push_back('{track_of(0, 0, 0, -524288, -524288, -524288, -524288, -524288,
			-524288, 16777215, 16777215), 1'b0, want});
		rows.push_back('{track_of(-524288, 524287, 0, 524287, -524288, 1, 0, 0, 0, 600000, 0),
			1'b0, want});
		rows.push_back('{track_of(0, 0, 0, 1, 0, 0, -1, 0, 0, 16777215, 1), 1'b0, want});
		rows.push_back('{track_of(0, 0, 0, 0, 0, -300000, 0, 0, -7, 160000, 5000000), 1'b0,
			want});
		rows.push_back('{track_of(0, 0, 0, 0, 1, 0, 0, 1, 0, 16777215, 16777215), 1'b0, want});
		foreach (rows[i])
			send_track(rows[i].tr, rows[i].typed, rows[i].want);

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			case (ph)
				0: begin
					vx = int'($urandom_range(0, 20000)) - 10000;
					vy = int'($urandom_range(0, 20000)) - 10000;
					vz = int'($urandom_range(0, 20000)) - 10000;
				end
				1: begin
					vx = 524287; vy = -524288; vz = 524287;
				end
				2: begin
					vx = -524288; vy = 524287; vz = -524288;
				end
				default: begin
					vx = int'($urandom_range(0, 1048575)) - 524288;
					vy = int'($urandom_range(0, 1048575)) - 524288;
					vz = int'($urandom_range(0, 1048575)) - 524288;
				end
			endcase
			write_vertex(REG_VERTEX_X, vx);
			write_vertex(REG_VERTEX_Y, vy);
			write_vertex(REG_VERTEX_Z, vz);
			if (ph == 3)
				write_vertex(REG_UNUSED, int'($urandom_range(0, 1048575)));
			long_hold = (ph == 1);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				no_idle = (ph == 2) && (i < 120);
				send_track(random_track(), 1'b0, want);
			end
			no_idle = 1'b0;
		end

		trk_valid = 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tof_track_momentum_top verification clean");
		else
			$display("tof_track_momentum_top verification failed");
		$finish;
	end

endmodule
